// ===== rtl/battery_gauge_trimmed_mean_bars_top_assert.svh =====
// Assertion helpers for the battery gauge block.
`ifndef BATTERY_GAUGE_TRIMMED_MEAN_BARS_TOP_ASSERT_SVH
`define BATTERY_GAUGE_TRIMMED_MEAN_BARS_TOP_ASSERT_SVH

// same-cycle implication
`define BTGM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTGM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/btgm_pkg.sv =====
`default_nettype none
package btgm_pkg;

  localparam int AdcBits  = 12;
  localparam int Window   = 10;
  localparam int CntW     = $clog2(Window + 1);
  localparam int SumW     = AdcBits + 2;
  localparam int FullW    = AdcBits + 1;
  localparam int MarginW  = 5;
  localparam int MvW      = 13;
  localparam int PctW     = 7;
  localparam int BarsW    = 3;
  // |(avg - empty) * 100| fits in AdcBits + 7 bits
  localparam int NumW     = AdcBits + 7;
  localparam int DenW     = FullW;
  localparam int DivCntW  = $clog2(NumW + 1);

  // divide by three: (x * Div3Recip) >> Div3Shift, exact for x < 2^Div3Shift
  localparam int Div3Shift = 19;
  localparam int Div3RecW  = 18;
  localparam logic [Div3RecW-1:0] Div3Recip = Div3RecW'((1 << Div3Shift) / 3 + 1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  localparam int InTdataW  = ((AdcBits + 7) / 8) * 8;
  localparam int OutBits   = AdcBits + MvW + PctW + BarsW + 1;
  localparam int OutTdataW = ((OutBits + 7) / 8) * 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EMPTY_CODE    = 3'd0,
    CFG_FULL_CODE     = 3'd1,
    CFG_RISE_MARGIN   = 3'd2,
    CFG_FALL_MARGIN   = 3'd3,
    CFG_FULL_SCALE_MV = 3'd4
  } btgm_cfg_e;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SUM,
    ST_AVG,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } btgm_state_e;

  // what one sort cell hands to its right neighbor
  typedef struct packed {
    logic               vld;
    logic               gt;
    logic [AdcBits-1:0] val;
  } btgm_link_t;

endpackage
`default_nettype wire

// ===== rtl/battery_gauge_trimmed_mean_bars_top.sv =====
// Channel   | Dir | Handshake                    | Payload (low bit up)
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | adc_sample[11:0]
// m_axis    | out | m_axis_tvalid/m_axis_tready  | adc_average, battery_mv, percent,
//           |     |                              | bars, bars_changed
// cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// Samples 1..9 of a group are taken one per cycle; each is inserted into a
// chain of ten sort cells in the cycle it is taken.
// The tenth sample starts a run with s_axis_tready low: sum,
// divide by three, scaling, 19 divider steps and then its done flag,
// bar update.
// The result sits in an output register; the next group collects meanwhile,
// and only its final step waits if the previous result was not taken.
// Reset is asynchronous, active low; cfg_ready_o is always high.
`default_nettype none
module battery_gauge_trimmed_mean_bars_top import btgm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,   // [11:0] adc_sample
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [11:0] adc_average, [24:12] battery_mv, [31:25] percent, [34:32] bars,
  // [35] bars_changed
  output logic [OutTdataW-1:0]      m_axis_tdata,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  `include "battery_gauge_trimmed_mean_bars_top_assert.svh"

  // configuration
  logic [AdcBits-1:0] empty_q;
  logic [FullW-1:0]   full_q;
  logic [MarginW-1:0] rise_q, fall_q;
  logic [MvW-1:0]     fsmv_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= AdcBits'(2900);
      full_q  <= FullW'(4096);
      rise_q  <= MarginW'(10);
      fall_q  <= MarginW'(5);
      fsmv_q  <= MvW'(4200);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EMPTY_CODE:    empty_q <= cfg_data_i[AdcBits-1:0];
        CFG_FULL_CODE:     full_q  <= cfg_data_i[FullW-1:0];
        CFG_RISE_MARGIN:   rise_q  <= cfg_data_i[MarginW-1:0];
        CFG_FALL_MARGIN:   fall_q  <= cfg_data_i[MarginW-1:0];
        CFG_FULL_SCALE_MV: fsmv_q  <= cfg_data_i[MvW-1:0];
        default: ;
      endcase
    end
  end

  // control
  btgm_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic            accept;
  logic            clr;
  logic            out_free;
  logic            load_out;
  logic            div_start;
  logic            div_done;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    clr           = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && cnt_q == CntW'(Window - 1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        clr     = 1'b1;
        state_d = ST_AVG;
      end
      ST_AVG: state_d = ST_PREP;
      ST_PREP: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= (cnt_q == CntW'(Window - 1)) ? '0 : cnt_q + 1'b1;
      end
    end
  end

  // sort chain
  btgm_link_t links [Window+1];

  assign links[0] = '{vld: 1'b1, gt: 1'b0, val: '0};

  for (genvar i = 0; i < Window; i++) begin : g_cell
    btgm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ins_i     (accept),
      .clr_i     (clr),
      .new_val_i (s_axis_tdata[AdcBits-1:0]),
      .prev_i    (links[i]),
      .link_o    (links[i+1])
    );
  end

  // datapath
  logic [SumW-1:0]               sum_q;
  logic [AdcBits-1:0]            avg_q;
  logic [SumW+Div3RecW-1:0]      avg_prod;
  logic [MvW-1:0]                mv_q;
  logic [AdcBits+MvW-1:0]        mv_prod;
  logic signed [AdcBits:0]       diff_s;
  logic signed [NumW:0]          num_s;
  logic signed [DenW:0]          den_s;
  logic [NumW-1:0]               num_abs;
  logic [DenW-1:0]               den_abs;
  logic                          neg_q, zero_q, ge_q;
  logic [NumW-1:0]               quo;

  assign avg_prod = SumW'(sum_q) * Div3Recip;
  assign mv_prod  = avg_q * fsmv_q;
  assign diff_s   = $signed({1'b0, avg_q}) - $signed({1'b0, empty_q});
  assign num_s    = diff_s * 8'sd100;
  assign den_s    = $signed({1'b0, full_q}) - $signed({2'b00, empty_q});
  // the divider loads these in the scaling cycle
  assign num_abs  = num_s[NumW] ? NumW'(-num_s) : num_s[NumW-1:0];
  assign den_abs  = den_s[DenW] ? DenW'(-den_s) : den_s[DenW-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      // sorted positions 4, 5, 6
      sum_q <= SumW'(links[5].val) + SumW'(links[6].val) + SumW'(links[7].val);
    end
    if (state_q == ST_AVG) begin
      avg_q <= avg_prod[Div3Shift +: AdcBits];
    end
    if (state_q == ST_PREP) begin
      mv_q      <= mv_prod[AdcBits +: MvW];
      neg_q     <= diff_s[AdcBits] ^ den_s[DenW];
      zero_q    <= (den_s == '0);
      ge_q      <= !diff_s[AdcBits];
    end
  end

  btgm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_abs),
    .divisor_i  (den_abs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // percent and bars
  logic [PctW-1:0]  pct;
  logic [BarsW-1:0] bar_q, bar_d;
  logic             first_q;
  logic             changed;
  logic [8:0]       up_lim;
  logic [8:0]       dn_lhs;
  logic [8:0]       dn_lim;

  always_comb begin
    if (zero_q) begin
      pct = ge_q ? PctW'(100) : '0;
    end else if (neg_q) begin
      // truncated toward zero, then clamped
      pct = '0;
    end else if (quo > NumW'(100)) begin
      pct = PctW'(100);
    end else begin
      pct = quo[PctW-1:0];
    end
  end

  assign up_lim = 9'(bar_q) * 9'd20 + 9'(rise_q);
  assign dn_lhs = 9'(pct) + 9'(fall_q);
  assign dn_lim = (9'(bar_q) - 9'd1) * 9'd20;

  always_comb begin
    bar_d   = bar_q;
    changed = 1'b0;
    if (!first_q) begin
      if (pct >= PctW'(100))     bar_d = BarsW'(5);
      else if (pct >= PctW'(75)) bar_d = BarsW'(4);
      else if (pct >= PctW'(50)) bar_d = BarsW'(3);
      else if (pct >= PctW'(25)) bar_d = BarsW'(2);
      else                       bar_d = BarsW'(1);
    end else if (9'(pct) >= up_lim) begin
      if (bar_q < BarsW'(5)) begin
        bar_d   = bar_q + 1'b1;
        changed = 1'b1;
      end
    end else if (dn_lhs <= dn_lim) begin
      if (bar_q > BarsW'(1)) begin
        bar_d   = bar_q - 1'b1;
        changed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_q         <= BarsW'(1);
      first_q       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        bar_q         <= bar_d;
        first_q       <= 1'b1;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_axis_tdata <= OutTdataW'({changed, bar_d, pct, mv_q, avg_q});
    end
  end

  `BTGM_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q < CntW'(Window), "sample count out of range")
  `BTGM_ASSERT_IMP(a_pct_range, m_axis_tvalid, m_axis_tdata[31:25] <= PctW'(100),
                   "percent above 100")
  `BTGM_ASSERT_IMP(a_bars_range, m_axis_tvalid,
                   m_axis_tdata[34:32] >= BarsW'(1) && m_axis_tdata[34:32] <= BarsW'(5),
                   "bars out of range")
  `BTGM_ASSERT_IMP(a_mid_sorted, state_q == ST_SUM,
                   links[5].val <= links[6].val && links[6].val <= links[7].val,
                   "middle cells not sorted")
  `BTGM_ASSERT_IMP(a_div_done, div_done, state_q == ST_DIV, "divider done outside wait")
  `BTGM_ASSERT_NXT(a_prep_div, state_q == ST_PREP, state_q == ST_DIV, "divider not started")

endmodule
`default_nettype wire

// ===== rtl/btgm_cell.sv =====
`default_nettype none
module btgm_cell import btgm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               ins_i,
  input  wire logic               clr_i,
  input  wire logic [AdcBits-1:0] new_val_i,
  input  wire btgm_link_t         prev_i,
  output btgm_link_t              link_o
);

  logic               vld_q;
  logic [AdcBits-1:0] val_q, val_d;
  logic               gt;
  logic               take;

  assign gt   = vld_q && (val_q > new_val_i);
  // empty cell right of the last filled one, or a cell whose value moves up
  assign take = ins_i && prev_i.vld && (!vld_q || gt);

  always_comb begin
    val_d = val_q;
    if (take) begin
      val_d = prev_i.gt ? prev_i.val : new_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clr_i) begin
      vld_q <= 1'b0;
    end else if (ins_i && prev_i.vld) begin
      vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o = '{vld: vld_q, gt: gt, val: val_q};

endmodule
`default_nettype wire

// ===== rtl/btgm_div.sv =====
`default_nettype none
module btgm_div import btgm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] dividend_i,
  input  wire logic [DenW-1:0] divisor_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quotient_o
);

  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic [NumW-1:0]    quo_q;
  logic [DenW-1:0]    rem_q;
  logic [DenW-1:0]    dvs_q;
  logic [DenW:0]      rem_sh;
  logic               fits;
  logic [DenW:0]      rem_sub;

  // restoring division, one quotient bit per cycle, MSB first
  assign rem_sh  = {rem_q, quo_q[NumW-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NumW-2:0], fits};
      rem_q <= fits ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
    end
  end

  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_battery_gauge_trimmed_mean_bars_top.sv =====
module tb_battery_gauge_trimmed_mean_bars_top import btgm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 3000;
  localparam int SettleCycles = 40;  // one full run plus margin
  localparam int PhaseItems = 103;

  // low field in the low bits, matching m_axis_tdata
  typedef struct packed {
    logic               bars_changed;
    logic [BarsW-1:0]   bars;
    logic [PctW-1:0]    percent;
    logic [MvW-1:0]     battery_mv;
    logic [AdcBits-1:0] adc_average;
  } gauge_reading_t;

  typedef struct packed {
    logic [InTdataW-1:0] word;
    logic                typed;
    gauge_reading_t      want;
  } dir_row_t;

  typedef struct {
    int empty_cd;
    int full_cd;
    int rise;
    int fall;
    int fsmv;
  } gauge_setting_t;

  // group of six highs and four lows right after reset: first reading sets bars directly
  localparam gauge_reading_t ReadAllHigh = '{bars_changed: 1'b0, bars: 3'd4,
                                             percent: 7'd99, battery_mv: 13'd4198,
                                             adc_average: 12'd4095};
  // group of seven lows and three highs next: 0 percent drops one bar
  localparam gauge_reading_t ReadAllLow = '{bars_changed: 1'b1, bars: 3'd3,
                                            percent: 7'd0, battery_mv: 13'd0,
                                            adc_average: 12'd0};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  // predictor state
  logic [AdcBits-1:0] held_samples [Window];
  int                 held_count = 0;
  int                 bar_level = 1;
  bit                 have_first = 1'b0;
  int                 cfg_empty = 2900;
  int                 cfg_full = 4096;
  int                 cfg_rise = 10;
  int                 cfg_fall = 5;
  int                 cfg_fsmv = 4200;

  gauge_reading_t readings_due [$];
  dir_row_t       dir_rows [25];
  bit             gaps_on = 1'b1;
  int             bad_count = 0;
  int             quiet_cycles = 0;

  always #6ns clk_i = ~clk_i;

  battery_gauge_trimmed_mean_bars_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  task automatic absorb_sample(input logic [InTdataW-1:0] word, output bit produced,
                               output gauge_reading_t rd);
    int sorted [Window];
    int v, j, avg, mv, num, den, pct, lvl;
    bit chg;
    produced = 1'b0;
    rd = '0;
    chg = 1'b0;
    held_samples[held_count] = word[AdcBits-1:0];
    held_count++;
    if (held_count < Window) return;
    held_count = 0;
    for (int i = 0; i < Window; i++) begin
      v = held_samples[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    avg = (sorted[4] + sorted[5] + sorted[6]) / 3;
    mv = (avg * cfg_fsmv) >> AdcBits;
    num = (avg - cfg_empty) * 100;
    den = cfg_full - cfg_empty;
    if (den == 0) begin
      pct = (avg >= cfg_empty) ? 100 : 0;
    end else begin
      pct = num / den;  // truncates toward zero
      if (pct < 0) pct = 0;
      if (pct > 100) pct = 100;
    end
    lvl = bar_level;
    if (!have_first) begin
      lvl = pct * 4 / 100 + 1;
      have_first = 1'b1;
    end else if (pct >= lvl * 20 + cfg_rise) begin
      if (lvl < 5) begin
        lvl++;
        chg = 1'b1;
      end
    end else if (pct <= (lvl - 1) * 20 - cfg_fall) begin
      if (lvl > 1) begin
        lvl--;
        chg = 1'b1;
      end
    end
    bar_level = lvl;
    rd.adc_average = AdcBits'(avg);
    rd.battery_mv = MvW'(mv);
    rd.percent = PctW'(pct);
    rd.bars = BarsW'(lvl);
    rd.bars_changed = chg;
    produced = 1'b1;
  endtask

  task automatic feed_sample(input logic [InTdataW-1:0] word, input bit typed,
                             input gauge_reading_t want);
    bit             produced;
    gauge_reading_t rd;
    if (gaps_on) begin
      while ($urandom_range(99) < 10) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    absorb_sample(word, produced, rd);
    if (produced) readings_due.push_back(typed ? want : rd);
  endtask

  task automatic write_reg(input btgm_cfg_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_EMPTY_CODE:    cfg_empty = value & 'hFFF;
      CFG_FULL_CODE:     cfg_full = value & 'h1FFF;
      CFG_RISE_MARGIN:   cfg_rise = value & 'h1F;
      CFG_FALL_MARGIN:   cfg_fall = value & 'h1F;
      CFG_FULL_SCALE_MV: cfg_fsmv = value & 'h1FFF;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input gauge_setting_t s);
    write_reg(CFG_EMPTY_CODE, s.empty_cd);
    write_reg(CFG_FULL_CODE, s.full_cd);
    write_reg(CFG_RISE_MARGIN, s.rise);
    write_reg(CFG_FALL_MARGIN, s.fall);
    write_reg(CFG_FULL_SCALE_MV, s.fsmv);
    cfg_valid_i <= 1'b0;
  endtask

  // samples 1..9 give no reading, so allow a full run after the last one
  task automatic drain_readings();
    s_axis_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic report_bad(input string what, input gauge_reading_t want,
                            input gauge_reading_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%0t %s: want avg=%0d mv=%0d pct=%0d bars=%0d chg=%0d", $realtime, what,
               want.adc_average, want.battery_mv, want.percent, want.bars,
               want.bars_changed);
      $display("    got avg=%0d mv=%0d pct=%0d bars=%0d chg=%0d", got.adc_average,
               got.battery_mv, got.percent, got.bars, got.bars_changed);
    end
  endtask

  always @(posedge clk_i) begin
    gauge_reading_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OutBits-1:0];
        if (readings_due.size() == 0) begin
          report_bad("reading with none due", '0, got);
        end else begin
          want = readings_due.pop_front();
          if (got.adc_average !== want.adc_average || got.battery_mv !== want.battery_mv ||
              got.percent !== want.percent || got.bars !== want.bars ||
              got.bars_changed !== want.bars_changed) begin
            report_bad("reading mismatch", want, got);
          end
        end
      end
      m_axis_tready <= !(gaps_on && $urandom_range(99) < 10);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    gauge_setting_t fixed_set [4];
    gauge_setting_t s;
    int lo, hi, wlo, whi, step, level, smp;
    bit wild;
    logic [InTdataW-1:0] word;

    // interleaved highs and lows check the sort; padded words check that
    // bits above the sample width are dropped
    dir_rows = '{
      '{16'h0FFF, 1'b0, '0}, '{16'h0000, 1'b0, '0}, '{16'h0FFF, 1'b0, '0},
      '{16'h0000, 1'b0, '0}, '{16'h0FFF, 1'b0, '0}, '{16'h0000, 1'b0, '0},
      '{16'h0FFF, 1'b0, '0}, '{16'h0000, 1'b0, '0}, '{16'h0FFF, 1'b0, '0},
      '{16'h0FFF, 1'b1, ReadAllHigh},
      '{16'hF000, 1'b0, '0}, '{16'hFFFF, 1'b0, '0}, '{16'h0000, 1'b0, '0},
      '{16'h5000, 1'b0, '0}, '{16'hFFFF, 1'b0, '0}, '{16'hA000, 1'b0, '0},
      '{16'h0000, 1'b0, '0}, '{16'h0FFF, 1'b0, '0}, '{16'hF000, 1'b0, '0},
      '{16'h0000, 1'b1, ReadAllLow},
      '{16'h0800, 1'b0, '0}, '{16'h07FF, 1'b0, '0}, '{16'h0555, 1'b0, '0},
      '{16'h0AAA, 1'b0, '0}, '{16'h0001, 1'b0, '0}
    };
    // widest span, inverted span, zero span, mild inverted span
    fixed_set[0] = '{0, 4096, 0, 0, 8191};
    fixed_set[1] = '{4095, 1, 20, 20, 0};
    fixed_set[2] = '{2048, 2048, 5, 3, 4200};
    fixed_set[3] = '{3500, 1200, 7, 12, 5000};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) feed_sample(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);

    for (int ph = 0; ph < 9; ph++) begin
      drain_readings();
      if (ph < 4) begin
        s = fixed_set[ph];
      end else if (ph == 8) begin
        s = '{2900, 4096, 10, 5, 4200};
      end else begin
        s.empty_cd = $urandom_range(4095);
        s.full_cd = (ph == 7) ? $urandom_range(1, 4096) : $urandom_range(s.empty_cd + 1, 4096);
        s.rise = $urandom_range(20);
        s.fall = $urandom_range(20);
        s.fsmv = $urandom_range(8191);
      end
      apply_setting(s);
      gaps_on = (ph != 5);

      lo = (s.empty_cd < s.full_cd) ? s.empty_cd : s.full_cd;
      hi = (s.empty_cd < s.full_cd) ? s.full_cd : s.empty_cd;
      wlo = (lo > 300) ? lo - 300 : 0;
      whi = (hi + 300 > 4095) ? 4095 : hi + 300;
      step = ((whi - wlo) / 4 > 8) ? (whi - wlo) / 4 : 8;
      level = $urandom_range(wlo, whi);
      wild = 1'b0;
      for (int n = 0; n < PhaseItems; n++) begin
        // the level wanders slowly so the bar count climbs and falls
        if (n % Window == 0) begin
          level = level + $urandom_range(2 * step) - step;
          if (level < wlo) level = wlo;
          if (level > whi) level = whi;
          wild = ($urandom_range(99) < 15);
        end
        if (wild) begin
          smp = $urandom_range(4095);
        end else if ($urandom_range(99) < 10) begin
          smp = $urandom_range(1) ? 4095 : 0;
        end else begin
          smp = level + $urandom_range(32) - 16;
          if (smp < 0) smp = 0;
          if (smp > 4095) smp = 4095;
        end
        word = InTdataW'(smp);
        if ($urandom_range(99) < 6) begin
          word[InTdataW-1:AdcBits] = (InTdataW - AdcBits)'($urandom_range(1, 15));
        end
        feed_sample(word, 1'b0, '0);
      end
    end

    drain_readings();
    if (bad_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
